/* hw/rtl/whc_pkg.sv */
// Shared types, constants and the message schedule table for the wide hash compression block.
package whc_pkg;

  typedef enum logic [1:0] {
    OP_CHAIN = 2'd0,
    OP_MSG   = 2'd1,
    OP_START = 2'd2
  } whc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PRIME = 2'd1,
    ST_MIX   = 2'd2,
    ST_OUT   = 2'd3
  } whc_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  word_index;
    logic [63:0] data_word;
    logic [63:0] block_counter;
    logic [7:0]  block_length;
    logic [31:0] flag_bits;
  } whc_in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  out_index;
    logic        out_last;
  } whc_out_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic       in_ready;
    logic       mix;
    logic [1:0] phase;
    logic [2:0] g_step;
    logic       emit;
    logic [3:0] out_cnt;
    logic [3:0] rd_row;
    logic [3:0] rd_col;
  } whc_ctrl_t;

  localparam int unsigned ROT_0 = 32;
  localparam int unsigned ROT_1 = 24;
  localparam int unsigned ROT_2 = 16;
  localparam int unsigned ROT_3 = 63;

  localparam logic [63:0] WHC_IV [8] = '{
    64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
    64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
    64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
    64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
  };

  localparam logic [3:0] WHC_PERM [10][16] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
      4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
    '{4'd14, 4'd10, 4'd4,  4'd8,  4'd9,  4'd15, 4'd13, 4'd6,
      4'd1,  4'd12, 4'd0,  4'd2,  4'd11, 4'd7,  4'd5,  4'd3},
    '{4'd11, 4'd8,  4'd12, 4'd0,  4'd5,  4'd2,  4'd15, 4'd13,
      4'd10, 4'd14, 4'd3,  4'd6,  4'd7,  4'd1,  4'd9,  4'd4},
    '{4'd7,  4'd9,  4'd3,  4'd1,  4'd13, 4'd12, 4'd11, 4'd14,
      4'd2,  4'd6,  4'd5,  4'd10, 4'd4,  4'd0,  4'd15, 4'd8},
    '{4'd9,  4'd0,  4'd5,  4'd7,  4'd2,  4'd4,  4'd10, 4'd15,
      4'd14, 4'd1,  4'd11, 4'd12, 4'd6,  4'd8,  4'd3,  4'd13},
    '{4'd2,  4'd12, 4'd6,  4'd10, 4'd0,  4'd11, 4'd8,  4'd3,
      4'd4,  4'd13, 4'd7,  4'd5,  4'd15, 4'd14, 4'd1,  4'd9},
    '{4'd12, 4'd5,  4'd1,  4'd15, 4'd14, 4'd13, 4'd4,  4'd10,
      4'd0,  4'd7,  4'd6,  4'd3,  4'd9,  4'd2,  4'd8,  4'd11},
    '{4'd13, 4'd11, 4'd7,  4'd14, 4'd12, 4'd1,  4'd3,  4'd9,
      4'd5,  4'd0,  4'd15, 4'd4,  4'd8,  4'd6,  4'd2,  4'd10},
    '{4'd6,  4'd15, 4'd14, 4'd9,  4'd11, 4'd3,  4'd0,  4'd8,
      4'd12, 4'd2,  4'd13, 4'd7,  4'd1,  4'd4,  4'd10, 4'd5},
    '{4'd10, 4'd2,  4'd8,  4'd4,  4'd7,  4'd6,  4'd1,  4'd5,
      4'd15, 4'd11, 4'd9,  4'd14, 4'd3,  4'd12, 4'd13, 4'd0}
  };

  function automatic logic [3:0] perm_word(logic [3:0] row, logic [3:0] col);
    logic [3:0] sel;
    sel = 4'd0;
    if (row < 4'd10) begin
      sel = WHC_PERM[row][col];
    end
    return sel;
  endfunction

  function automatic logic [63:0] rotr64(logic [63:0] x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

/* hw/rtl/whc_gmix.sv */
// Shared mixing unit: one quarter of a G function per cycle, one adder and one xor-rotate.
module whc_gmix (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [63:0] c_i,
  input  logic [63:0] d_i,
  input  logic [63:0] m_i,
  input  logic [1:0]  phase_i,
  output logic [63:0] a_o,
  output logic [63:0] b_o,
  output logic [63:0] c_o,
  output logic [63:0] d_o
);
  import whc_pkg::*;

  logic        step_b;
  logic [63:0] op_x;
  logic [63:0] op_y;
  logic [63:0] op_z;
  logic [63:0] sum;
  logic [63:0] mix_v;
  logic [63:0] rot_v;

  // Even phases update a and d, odd phases update c and b.
  assign step_b = phase_i[0];
  assign op_x   = step_b ? c_i : a_i;
  assign op_y   = step_b ? d_i : b_i;
  assign op_z   = step_b ? 64'd0 : m_i;
  assign sum    = op_x + op_y + op_z;
  assign mix_v  = (step_b ? b_i : d_i) ^ sum;

  always_comb begin
    case (phase_i)
      2'd0:    rot_v = rotr64(mix_v, ROT_0);
      2'd1:    rot_v = rotr64(mix_v, ROT_1);
      2'd2:    rot_v = rotr64(mix_v, ROT_2);
      default: rot_v = rotr64(mix_v, ROT_3);
    endcase
  end

  assign a_o = step_b ? a_i : sum;
  assign d_o = step_b ? d_i : rot_v;
  assign c_o = step_b ? sum : c_i;
  assign b_o = step_b ? rot_v : b_i;

endmodule

/* hw/rtl/whc_seq.sv */
// Sequencer: round, G step and phase counters plus output word count.
module whc_seq #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                emit_free_i,
  output whc_pkg::whc_ctrl_t  ctrl_o
);
  import whc_pkg::*;

  localparam int unsigned RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUND_COUNT - 1);

  whc_state_e       state_q, state_d;
  logic [RND_W-1:0] round_q, round_d;
  logic [2:0]       g_q, g_d;
  logic [1:0]       phase_q, phase_d;
  logic [3:0]       cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      g_q     <= '0;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      g_q     <= g_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    g_d     = g_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ctrl_o  = '0;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (start_i) begin
          state_d = ST_PRIME;
        end
      end
      // Priming state: the first message word read lands in m_q before mixing starts.
      ST_PRIME: begin
        state_d = ST_MIX;
        round_d = '0;
        g_d     = '0;
        phase_d = '0;
      end
      ST_MIX: begin
        ctrl_o.mix = 1'b1;
        phase_d    = phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          g_d = g_q + 3'd1;
          if (g_q == 3'd7) begin
            if (round_q == RND_LAST) begin
              state_d = ST_OUT;
              round_d = '0;
              cnt_d   = '0;
            end else begin
              round_d = round_q + 1'b1;
            end
          end
        end
      end
      ST_OUT: begin
        if (emit_free_i) begin
          ctrl_o.emit = 1'b1;
          cnt_d       = cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    ctrl_o.phase   = phase_q;
    ctrl_o.g_step  = g_q;
    ctrl_o.out_cnt = cnt_q;
    // Address the word the next cycle's phase consumes.
    ctrl_o.rd_row  = 4'(round_d);
    ctrl_o.rd_col  = {g_d, phase_d[1]};
  end

endmodule

/* hw/rtl/wide_hash_compression.sv */
// Top level of the wide hash compression block: stores, working state and output register.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one request per item:
// a chaining word load, a message word load or a start. Loads produce nothing; a
// chaining load with index 8 to 15 and op 3 are dropped. A start builds the working
// state from the chaining words, the IV and the block counter, length and flags,
// then runs ROUND_COUNT rounds on one shared adder/xor-rotate unit, one quarter G
// per cycle, through a priming state and then the mixing state. The sixteen output
// words then leave through the output register at one per cycle while the receiver
// does not stall. in_ready_o is low from the start until the last word sits in the
// output register; it rises while that word still waits. Output stalls (out_ready_i
// low) hold the output register and pause emission. Reset clears the sequencer and
// the output valid; the stores and the working state hold undefined data until
// loaded.
module wide_hash_compression #(
  parameter int unsigned ROUND_COUNT = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  whc_pkg::whc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output whc_pkg::whc_out_t out_data_o
);
  import whc_pkg::*;

  whc_ctrl_t   ctrl;
  logic        in_acc;
  logic        start;
  logic        emit_free;
  logic [63:0] chain_q [8];
  logic [63:0] msg_mem [16];
  logic [63:0] m_q;
  logic [63:0] v_q [16];
  logic [63:0] v_d [16];
  logic [63:0] v_mix [16];
  logic [63:0] a_n, b_n, c_n, d_n;
  logic        out_valid_q, out_valid_d;
  whc_out_t    out_q;
  logic [63:0] out_word;

  assign in_acc    = in_valid_i && ctrl.in_ready;
  assign start     = in_acc && (in_data_i.op == OP_START);
  assign emit_free = !out_valid_q || out_ready_i;

  whc_seq #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .emit_free_i (emit_free),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.op == OP_CHAIN) && !in_data_i.word_index[3]) begin
      chain_q[in_data_i.word_index[2:0]] <= in_data_i.data_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_data_i.op == OP_MSG)) begin
      msg_mem[in_data_i.word_index] <= in_data_i.data_word;
    end
    m_q <= msg_mem[perm_word(ctrl.rd_row, ctrl.rd_col)];
  end

  // The unit always works on column zero of the four rows.
  whc_gmix u_gmix (
    .a_i     (v_q[0]),
    .b_i     (v_q[4]),
    .c_i     (v_q[8]),
    .d_i     (v_q[12]),
    .m_i     (m_q),
    .phase_i (ctrl.phase),
    .a_o     (a_n),
    .b_o     (b_n),
    .c_o     (c_n),
    .d_o     (d_n)
  );

  always_comb begin
    v_mix     = v_q;
    v_mix[0]  = a_n;
    v_mix[4]  = b_n;
    v_mix[8]  = c_n;
    v_mix[12] = d_n;
    v_d       = v_q;
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v_d[i]     = chain_q[i];
        v_d[i + 8] = WHC_IV[i];
      end
      v_d[12] = WHC_IV[4] ^ in_data_i.block_counter;
      v_d[14] = WHC_IV[6] ^ {56'd0, in_data_i.block_length};
      v_d[15] = WHC_IV[7] ^ {32'd0, in_data_i.flag_bits};
    end else if (ctrl.mix) begin
      v_d = v_mix;
      if (ctrl.phase == 2'd3) begin
        // Advance each row by one word; diagonalize after the last column step
        // and restore the row order after the last diagonal step.
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 4; j++) begin
            if (ctrl.g_step == 3'd3) begin
              v_d[4 * r + j] = v_mix[4 * r + ((j + 1 + r) % 4)];
            end else if (ctrl.g_step == 3'd7) begin
              v_d[4 * r + j] = v_mix[4 * r + ((j + 5 - r) % 4)];
            end else begin
              v_d[4 * r + j] = v_mix[4 * r + ((j + 1) % 4)];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  always_comb begin
    if (!ctrl.out_cnt[3]) begin
      out_word = v_q[{1'b0, ctrl.out_cnt[2:0]}] ^ v_q[{1'b1, ctrl.out_cnt[2:0]}];
    end else begin
      out_word = v_q[{1'b1, ctrl.out_cnt[2:0]}] ^ chain_q[ctrl.out_cnt[2:0]];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_q.out_word  <= out_word;
      out_q.out_index <= ctrl.out_cnt;
      out_q.out_last  <= (ctrl.out_cnt == 4'd15);
    end
  end

  assign in_ready_o  = ctrl.in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/whc_checker.sv */
// Port-level checks for the wide hash compression block and their bind.
module whc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input whc_pkg::whc_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input whc_pkg::whc_out_t out_data_o
);
  import whc_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // Taking the last word leaves nothing behind it.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.out_last |=> !out_valid_o)
    else $error("output after last word");

  // No request is taken while words of a compression are still coming.
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_last |-> !in_ready_o)
    else $error("ready during output burst");

  // A start makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.op == OP_START) |=> !in_ready_o)
    else $error("ready right after start");

  // The last word carries index fifteen.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_last |-> out_data_o.out_index == 4'd15)
    else $error("last flag on wrong index");

endmodule

bind wide_hash_compression whc_checker u_whc_checker (.*);

/* dv/tb_wide_hash_compression.sv */
// Testbench for wide_hash_compression: directed table plus random load/start sequences, self-checked.
`timescale 1ns / 100ps

module tb_wide_hash_compression;
  import whc_pkg::*;

  localparam int unsigned ROUNDS       = 10;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          HOLD_CYCLES  = 900;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          IDLE_LIMIT   = 5000;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct packed {
    whc_in_t req;
    logic    quiet;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  whc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  whc_out_t out_data;

  // Shadow copies of the block's stores and the mixing state.
  logic [63:0] chain_words [8];
  logic [63:0] msg_words [16];
  logic [63:0] mix_v [16];

  whc_out_t pending_digest [$];
  dir_row_t directed_rows [$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       burst_left = 0;
  bit       hold_req = 1'b0;

  wide_hash_compression #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] iv_word(int i);
    logic [63:0] w;
    case (i)
      0:       w = 64'h6A09E667F3BCC908;
      1:       w = 64'hBB67AE8584CAA73B;
      2:       w = 64'h3C6EF372FE94F82B;
      3:       w = 64'hA54FF53A5F1D36F1;
      4:       w = 64'h510E527FADE682D1;
      5:       w = 64'h9B05688C2B3E6C1F;
      6:       w = 64'h1F83D9ABFB41BD6B;
      default: w = 64'h5BE0CD19137E2179;
    endcase
    return w;
  endfunction

  // Message schedule row: nibble k holds the message slot for position k.
  function automatic logic [63:0] sched_row(int r);
    logic [63:0] s;
    case (r)
      0:       s = 64'hFEDC_BA98_7654_3210;
      1:       s = 64'h357B_20C1_6DF9_84AE;
      2:       s = 64'h4917_63EA_DF25_0C8B;
      3:       s = 64'h8F04_A562_EBCD_1397;
      4:       s = 64'hD386_CB1E_FA42_7509;
      5:       s = 64'h91EF_57D4_38B0_A6C2;
      6:       s = 64'hB829_3670_A4DE_F15C;
      7:       s = 64'hA268_4F05_931C_E7BD;
      8:       s = 64'h5A41_7D2C_803B_9EF6;
      default: s = 64'h0DC3_E9BF_5167_482A;
    endcase
    return s;
  endfunction

  function automatic logic [63:0] sched_word(logic [63:0] s, int k);
    return msg_words[s[4*k +: 4]];
  endfunction

  function automatic void mix_g(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    mix_v[a] = mix_v[a] + mix_v[b] + x;
    t = mix_v[d] ^ mix_v[a];
    mix_v[d] = {t[31:0], t[63:32]};
    mix_v[c] = mix_v[c] + mix_v[d];
    t = mix_v[b] ^ mix_v[c];
    mix_v[b] = {t[23:0], t[63:24]};
    mix_v[a] = mix_v[a] + mix_v[b] + y;
    t = mix_v[d] ^ mix_v[a];
    mix_v[d] = {t[15:0], t[63:16]};
    mix_v[c] = mix_v[c] + mix_v[d];
    t = mix_v[b] ^ mix_v[c];
    mix_v[b] = {t[62:0], t[63]};
  endfunction

  function automatic void compress_block(logic [63:0] counter, logic [7:0] len,
                                         logic [31:0] flags);
    logic [63:0] s;
    whc_out_t    w;
    for (int i = 0; i < 8; i++) begin
      mix_v[i]     = chain_words[i];
      mix_v[i + 8] = iv_word(i);
    end
    mix_v[12] = mix_v[12] ^ counter;
    mix_v[14] = mix_v[14] ^ {56'd0, len};
    mix_v[15] = mix_v[15] ^ {32'd0, flags};
    for (int r = 0; r < int'(ROUNDS); r++) begin
      s = sched_row(r % 10);
      mix_g(0, 4,  8, 12, sched_word(s, 0),  sched_word(s, 1));
      mix_g(1, 5,  9, 13, sched_word(s, 2),  sched_word(s, 3));
      mix_g(2, 6, 10, 14, sched_word(s, 4),  sched_word(s, 5));
      mix_g(3, 7, 11, 15, sched_word(s, 6),  sched_word(s, 7));
      mix_g(0, 5, 10, 15, sched_word(s, 8),  sched_word(s, 9));
      mix_g(1, 6, 11, 12, sched_word(s, 10), sched_word(s, 11));
      mix_g(2, 7,  8, 13, sched_word(s, 12), sched_word(s, 13));
      mix_g(3, 4,  9, 14, sched_word(s, 14), sched_word(s, 15));
    end
    for (int i = 0; i < 16; i++) begin
      w.out_word  = (i < 8) ? (mix_v[i] ^ mix_v[i + 8]) : (mix_v[i] ^ chain_words[i - 8]);
      w.out_index = 4'(i);
      w.out_last  = (i == 15);
      pending_digest.push_back(w);
    end
  endfunction

  // Drop chaining loads past slot 7 and unknown ops.
  function automatic void store_word(whc_in_t r);
    if (r.op == OP_CHAIN && !r.word_index[3]) begin
      chain_words[r.word_index[2:0]] = r.data_word;
    end else if (r.op == OP_MSG) begin
      msg_words[r.word_index] = r.data_word;
    end
  endfunction

  function automatic void absorb_request(whc_in_t r);
    if (r.op == OP_START) begin
      compress_block(r.block_counter, r.block_length, r.flag_bits);
    end else begin
      store_word(r);
    end
  endfunction

  function automatic whc_in_t random_request(logic [1:0] op);
    whc_in_t r;
    r.op            = op;
    r.word_index    = 4'($urandom_range(0, 15));
    r.data_word     = {$urandom, $urandom};
    r.block_counter = {$urandom, $urandom};
    r.block_length  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(129, 255))
                                                  : 8'($urandom_range(0, 128));
    r.flag_bits     = $urandom;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [3:0] idx, logic [63:0] data,
                                  logic [63:0] counter, logic [7:0] len, logic [31:0] flags,
                                  logic quiet);
    dir_row_t row;
    row.req.op            = op;
    row.req.word_index    = idx;
    row.req.data_word     = data;
    row.req.block_counter = counter;
    row.req.block_length  = len;
    row.req.flag_bits     = flags;
    row.quiet             = quiet;
    directed_rows.push_back(row);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_digest_word(whc_out_t got);
    whc_out_t want;
    if (pending_digest.size() == 0) begin
      flag_mismatch("output word with nothing pending", got.out_word, 64'd0);
    end else begin
      want = pending_digest.pop_front();
      if (got.out_word !== want.out_word) begin
        flag_mismatch($sformatf("out_word[%0d]", want.out_index), got.out_word, want.out_word);
      end
      if (got.out_index !== want.out_index) begin
        flag_mismatch("out_index", 64'(got.out_index), 64'(want.out_index));
      end
      if (got.out_last !== want.out_last) begin
        flag_mismatch($sformatf("out_last[%0d]", want.out_index), 64'(got.out_last),
                      64'(want.out_last));
      end
    end
  endtask

  // Offer one request; open a new burst with a random gap when the current one runs out.
  task automatic offer(whc_in_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      compare_digest_word(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: stall patterns of varying density, plus one long hold-off.
  initial begin
    int mode;
    int span;
    wait (rst_n);
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 64);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        repeat (span) begin
          case (mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    whc_in_t r;
    int      counted;
    int      n_loads;
    int      pick;
    counted = 0;

    // Fill every slot before the first start; then the special cases.
    add_row(OP_CHAIN,  4'd0,  64'h0000_0000_0000_0000, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd1,  64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd2,  64'h8000_0000_0000_0001, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd3,  64'h6A09_E667_F2BD_C948, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd4,  64'h0123_4567_89AB_CDEF, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd5,  64'hFEDC_BA98_7654_3210, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd6,  64'h5555_5555_AAAA_AAAA, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_CHAIN,  4'd7,  64'h0000_0001_0000_0000, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd0,  64'h0000_0000_0063_6261, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd1,  64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd2,  64'h0000_0000_0000_0000, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd3,  64'h8000_0000_0000_0000, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd4,  64'h0000_0000_0000_0001, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd5,  64'h0706_0504_0302_0100, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd6,  64'h0F0E_0D0C_0B0A_0908, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd7,  64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd8,  64'h5555_5555_5555_5555, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd9,  64'hDEAD_BEEF_CAFE_F00D, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd10, 64'h0000_FFFF_0000_FFFF, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd11, 64'hFFFF_0000_FFFF_0000, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd12, 64'h1234_5678_9ABC_DEF0, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd13, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd14, 64'h0F0F_0F0F_F0F0_F0F0, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_MSG,    4'd15, 64'h3333_CCCC_3333_CCCC, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_START,  4'd0,  64'd0, 64'd3, 8'd3, 32'd0, 1'b0);
    // Out-of-range chaining slot and unknown op must leave the stores alone.
    add_row(OP_CHAIN,  4'd12, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 8'd0, 32'd0, 1'b1);
    add_row(OP_UNUSED, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, '1, 8'hFF, '1, 1'b1);
    // Full counter and flags, length past a block, then the last-block shape.
    add_row(OP_START,  4'd15, '1, '1, 8'd255, 32'hFFFF_FFFF, 1'b0);
    add_row(OP_START,  4'd0,  64'd0, 64'd0, 8'd128, 32'd0, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < directed_rows.size(); i++) begin
      offer(directed_rows[i].req);
      if (directed_rows[i].quiet) begin
        store_word(directed_rows[i].req);
      end else begin
        absorb_request(directed_rows[i].req);
      end
    end

    // Random load sequences, mostly closed by a start; some noise and some cut short.
    hold_req = 1'b1;
    while (counted < RANDOM_ITEMS) begin
      n_loads = $urandom_range(0, 12);
      repeat (n_loads) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          r = random_request(OP_CHAIN);
          r.word_index[3] = 1'b0;
        end else if (pick < 18) begin
          r = random_request(OP_MSG);
        end else if (pick == 18) begin
          r = random_request(OP_CHAIN);
          r.word_index[3] = 1'b1;
        end else begin
          r = random_request(OP_UNUSED);
        end
        offer(r);
        absorb_request(r);
        if (pick < 18) counted++;
      end
      if ($urandom_range(0, 9) != 0) begin
        r = random_request(OP_START);
        case ($urandom_range(0, 7))
          0:       r.block_counter = '0;
          1:       r.block_counter = '1;
          default: ;
        endcase
        offer(r);
        absorb_request(r);
        counted++;
      end
    end
    in_valid <= 1'b0;

    while (pending_digest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
